>>> rtl/hpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_pkg
// Types and constants shared by the binary16 multiplier modules.
// ----------------------------------------------------------------------------
package hpm_pkg;

    localparam logic [15:0] QNAN_CODE     = 16'hFFFF;
    localparam logic [15:0] INF_ZERO_CODE = 16'h7FFF;
    localparam logic [15:0] POS_INF       = 16'h7C00;
    localparam logic [15:0] NEG_INF       = 16'hFC00;
    localparam logic [15:0] SIGN_BIT      = 16'h8000;
    localparam logic [15:0] EXP_BIAS      = 16'd15;

    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf_zero;
        logic        inf;
        logic [15:0] raw_exp;
        logic [21:0] raw_man;
    } t_dec;

endpackage

>>> rtl/hpm_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_unpack
// Field decode, special-case flags, exponent sum and significand product.
// ----------------------------------------------------------------------------
module hpm_unpack import hpm_pkg::*; (
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output t_dec        o_dec
);

    logic [4:0]  ea, eb;
    logic [9:0]  ma, mb;
    logic        a_sub, b_sub, a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [10:0] sig_a, sig_b;
    logic [4:0]  exp_a, exp_b;

    always_comb begin
        ea     = i_operand_a[14:10];
        eb     = i_operand_b[14:10];
        ma     = i_operand_a[9:0];
        mb     = i_operand_b[9:0];
        a_inf  = (ea == 5'd31) && (ma == '0);
        b_inf  = (eb == 5'd31) && (mb == '0);
        a_nan  = (ea == 5'd31) && (ma != '0);
        b_nan  = (eb == 5'd31) && (mb != '0);
        a_sub  = (ea == 5'd0) && (ma != '0);
        b_sub  = (eb == 5'd0) && (mb != '0);
        a_zero = (ea == 5'd0) && (ma == '0);
        b_zero = (eb == 5'd0) && (mb == '0);
        sig_a  = a_sub ? {1'b0, ma} : {1'b1, ma};
        sig_b  = b_sub ? {1'b0, mb} : {1'b1, mb};
        exp_a  = a_sub ? 5'd1 : ea;
        exp_b  = b_sub ? 5'd1 : eb;

        o_dec.sign     = i_operand_a[15] ^ i_operand_b[15];
        o_dec.nan      = a_nan || b_nan;
        o_dec.inf_zero = (a_inf && b_zero) || (a_zero && b_inf);
        o_dec.inf      = a_inf || b_inf;
        o_dec.raw_exp  = {11'd0, exp_a} + {11'd0, exp_b} - EXP_BIAS;
        o_dec.raw_man  = (a_zero || b_zero) ? 22'd0 : sig_a * sig_b;
    end

endmodule

>>> rtl/hpm_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_round
// Normalize, round to nearest even, handle subnormal and special cases, pack.
// ----------------------------------------------------------------------------
module hpm_round import hpm_pkg::*; (
    input  t_dec        i_dec,
    output logic [15:0] o_product
);

    logic [4:0]  lead, sh;
    logic [21:0] sman, tmp, lshift;
    logic [15:0] sexp, nexp, lamt, ramt, mag;
    logic [11:0] kept, sub_ru;
    logic [9:0]  nman;
    logic        rnd, sub_rnd;

    always_comb begin
        lead = '0;
        for (int i = 0; i < 22; i++) begin
            if (i_dec.raw_man[i]) begin
                lead = 5'(i);
            end
        end
        sh = 5'd20 - lead;
        if (lead == 5'd21) begin
            sexp = i_dec.raw_exp + 16'd1;
            sman = i_dec.raw_man;
        end else begin
            sexp = i_dec.raw_exp - {11'd0, sh};
            sman = i_dec.raw_man << (sh + 5'd1);
        end
        rnd  = sman[10] && (sman[11] || (sman[9:0] != '0));
        kept = {1'b0, sman[21:11]} + {11'd0, rnd};
        if (kept[11]) begin
            nexp = sexp + 16'd1;
            nman = kept[10:1];
        end else begin
            nexp = sexp;
            nman = kept[9:0];
        end

        // subnormal scaling
        lamt   = i_dec.raw_exp - 16'd1;
        ramt   = 16'd1 - i_dec.raw_exp;
        lshift = i_dec.raw_man << lamt[4:0];
        if ((i_dec.raw_exp >= 16'd1) && (i_dec.raw_exp <= 16'd45)) begin
            tmp = (lamt <= 16'd20) ? {1'b0, lshift[20:0]} : 22'd0;
        end else begin
            tmp = (ramt <= 16'd21) ? (i_dec.raw_man >> ramt[4:0]) : 22'd0;
        end
        sub_rnd = tmp[9] && (tmp[10] || (tmp[8:0] != '0));
        sub_ru  = {1'b0, tmp[20:10]} + {11'd0, sub_rnd};

        if ((nexp > 16'd30) && (nexp <= 16'd50)) begin
            mag = POS_INF;
        end else if ((nexp >= 16'd1) && (nexp <= 16'd30)) begin
            mag = {nexp[5:0], nman};
        end else begin
            mag = {5'd0, sub_ru[10:0]};
        end

        if (i_dec.nan) begin
            o_product = QNAN_CODE;
        end else if (i_dec.inf_zero) begin
            o_product = INF_ZERO_CODE;
        end else if (i_dec.inf) begin
            o_product = i_dec.sign ? NEG_INF : POS_INF;
        end else begin
            o_product = (i_dec.sign ? SIGN_BIT : 16'd0) | mag;
        end
    end

endmodule

>>> rtl/half_precision_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_precision_multiplier
// Binary16 multiplier with round to nearest even, one product per operand pair.
// ----------------------------------------------------------------------------
// channel  direction  signals
// input    in         i_valid, o_stall, i_operand_a, i_operand_b
// output   out        o_valid, i_stall, o_product
//
// two register stages: operand register, then product register
// one transaction per cycle while the output is not stalled
// the product path is the 11x11 multiply plus normalize and round
// synchronous active-low reset clears both valid flags
// output stall holds the product register and backs up into o_stall
// ----------------------------------------------------------------------------
module half_precision_multiplier import hpm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_product
);

    logic        r_v1, n_v1, r_v2, n_v2;
    logic [15:0] r_a, r_b, r_p, n_p;
    logic        adv1, adv2;
    t_dec        dec;

    hpm_unpack u_unpack (
        .i_operand_a (r_a),
        .i_operand_b (r_b),
        .o_dec       (dec)
    );

    hpm_round u_round (
        .i_dec     (dec),
        .o_product (n_p)
    );

    assign adv2    = !r_v2 || !i_stall;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign n_v1    = adv1 ? i_valid : r_v1;
    assign n_v2    = adv2 ? r_v1 : r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_a <= i_operand_a;
            r_b <= i_operand_b;
        end
        if (adv2) begin
            r_p <= n_p;
        end
    end

    assign o_valid   = r_v2;
    assign o_product = r_p;

endmodule

>>> rtl/hpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpm_checker
// Port-level checks for the binary16 multiplier.
// ----------------------------------------------------------------------------
module hpm_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_product
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_product))
        else $error("stalled transaction changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_stall |=> ##1 o_valid)
        else $error("accepted transaction lost");

endmodule

bind half_precision_multiplier hpm_port_checks u_hpm_port_checks (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_product (o_product)
);
